>>> hdl/blp_pkg.sv
// Package for the line stepper: request codes, default sizes and the
// width of the command word that travels from front end to back end.
// No dependencies.
package blp_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // is_tick, x, y, step signs, major flag, decision, two increments, count
    function automatic int cmd_bits(input int n);
        return 1 + 2 * n + 3 + 3 * (n + 2) + (n + 1);
    endfunction

endpackage

>>> hdl/blp_front.sv
// Front end: accepts requests and turns a load into the full line setup.
// Depends on blp_pkg; feeds blp_queue.
module blp_front import blp_pkg::*; #(
    parameter int N = COORD_BITS_DEF
) (
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_req_type,
    input  logic [N-1:0]           i_x_start,
    input  logic [N-1:0]           i_y_start,
    input  logic [N-1:0]           i_x_end,
    input  logic [N-1:0]           i_y_end,
    input  logic                   i_q_ready,
    output logic                   o_q_push,
    output logic [cmd_bits(N)-1:0] o_q_data
);

    typedef struct packed {
        logic           is_tick;
        logic [N-1:0]   x;
        logic [N-1:0]   y;
        logic           sxn;
        logic           syn;
        logic           xmaj;
        logic [N+1:0]   dec;
        logic [N+1:0]   inc_s;
        logic [N+1:0]   inc_d;
        logic [N:0]     count;
    } t_cmd;

    t_cmd         cmd;
    logic         gt_x;
    logic         gt_y;
    logic [N-1:0] dx;
    logic [N-1:0] dy;
    logic [N+1:0] dx2;
    logic [N+1:0] dy2;
    logic         major;

    always_comb begin
        gt_x  = i_x_end > i_x_start;
        gt_y  = i_y_end > i_y_start;
        dx    = gt_x ? i_x_end - i_x_start : i_x_start - i_x_end;
        dy    = gt_y ? i_y_end - i_y_start : i_y_start - i_y_end;
        dx2   = {1'b0, dx, 1'b0};
        dy2   = {1'b0, dy, 1'b0};
        major = dx > dy;

        cmd.is_tick = (i_req_type == REQ_TICK);
        cmd.x       = i_x_start;
        cmd.y       = i_y_start;
        cmd.sxn     = !gt_x;
        cmd.syn     = !gt_y;
        cmd.xmaj    = major;
        if (major) begin
            cmd.dec   = dy2 - {2'b00, dx};
            cmd.inc_s = dy2;
            cmd.inc_d = dy2 - dx2;
            cmd.count = {1'b0, dx} + (N+1)'(1);
        end else begin
            cmd.dec   = dx2 - {2'b00, dy};
            cmd.inc_s = dx2;
            cmd.inc_d = dx2 - dy2;
            cmd.count = {1'b0, dy} + (N+1)'(1);
        end
    end

    assign o_ready  = i_q_ready;
    assign o_q_push = i_valid && i_q_ready;
    assign o_q_data = cmd;

endmodule

>>> hdl/blp_queue.sv
// Short command queue between front end and back end.
// Depends on blp_pkg for the default depth.
module blp_queue import blp_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/blp_back.sv
// Back end: holds the running line, steps it one pixel per tick and
// drives the registered pixel output. Depends on blp_pkg; fed by blp_queue.
module blp_back import blp_pkg::*; #(
    parameter int N = COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  logic [cmd_bits(N)-1:0] i_q_data,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [N-1:0]           o_pixel_x,
    output logic [N-1:0]           o_pixel_y,
    output logic                   o_last
);

    typedef struct packed {
        logic           is_tick;
        logic [N-1:0]   x;
        logic [N-1:0]   y;
        logic           sxn;
        logic           syn;
        logic           xmaj;
        logic [N+1:0]   dec;
        logic [N+1:0]   inc_s;
        logic [N+1:0]   inc_d;
        logic [N:0]     count;
    } t_cmd;

    function automatic logic [N-1:0] step_coord(input logic [N-1:0] c, input logic neg);
        return neg ? c - N'(1) : c + N'(1);
    endfunction

    t_cmd         cmd;
    logic         pop;
    logic         emit;
    logic         straight;

    logic [N-1:0] r_cur_x, n_cur_x;
    logic [N-1:0] r_cur_y, n_cur_y;
    logic [N+1:0] r_dec, n_dec;
    logic [N+1:0] r_inc_s, n_inc_s;
    logic [N+1:0] r_inc_d, n_inc_d;
    logic         r_sxn, n_sxn;
    logic         r_syn, n_syn;
    logic         r_xmaj, n_xmaj;
    logic [N:0]   r_left, n_left;
    logic         r_active, n_active;
    logic         r_out_valid, n_out_valid;
    logic [N-1:0] r_pix_x;
    logic [N-1:0] r_pix_y;
    logic         r_last;

    assign cmd  = i_q_data;
    assign pop  = i_q_valid && (!r_out_valid || i_ready);
    assign emit = pop && cmd.is_tick && r_active;

    // x-major goes straight on a negative decision, y-major on a non-positive one
    assign straight = r_xmaj ? r_dec[N+1] : (r_dec[N+1] || r_dec == '0);

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_dec    = r_dec;
        n_inc_s  = r_inc_s;
        n_inc_d  = r_inc_d;
        n_sxn    = r_sxn;
        n_syn    = r_syn;
        n_xmaj   = r_xmaj;
        n_left   = r_left;
        n_active = r_active;
        if (pop && !cmd.is_tick) begin
            n_cur_x  = cmd.x;
            n_cur_y  = cmd.y;
            n_dec    = cmd.dec;
            n_inc_s  = cmd.inc_s;
            n_inc_d  = cmd.inc_d;
            n_sxn    = cmd.sxn;
            n_syn    = cmd.syn;
            n_xmaj   = cmd.xmaj;
            n_left   = cmd.count;
            n_active = 1'b1;
        end else if (emit) begin
            n_left   = r_left - (N+1)'(1);
            n_active = r_left != (N+1)'(1);
            if (straight) begin
                n_dec = r_dec + r_inc_s;
            end else begin
                n_dec = r_dec + r_inc_d;
            end
            if (r_xmaj || !straight) begin
                n_cur_x = step_coord(r_cur_x, r_sxn);
            end
            if (!r_xmaj || !straight) begin
                n_cur_y = step_coord(r_cur_y, r_syn);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x <= n_cur_x;
        r_cur_y <= n_cur_y;
        r_dec   <= n_dec;
        r_inc_s <= n_inc_s;
        r_inc_d <= n_inc_d;
        r_sxn   <= n_sxn;
        r_syn   <= n_syn;
        r_xmaj  <= n_xmaj;
        r_left  <= n_left;
        if (emit) begin
            r_pix_x <= r_cur_x;
            r_pix_y <= r_cur_y;
            r_last  <= r_left == (N+1)'(1);
        end
    end

    assign o_q_pop   = pop;
    assign o_valid   = r_out_valid;
    assign o_pixel_x = r_pix_x;
    assign o_pixel_y = r_pix_y;
    assign o_last    = r_last;

endmodule

>>> hdl/bresenham_line_stepper.sv
// Bresenham line stepper. A load request (tuser = 0) sets up a line between
// two endpoints; each tick request (tuser = 1) yields the next pixel, first
// endpoint to second, with tlast on the final one. A load during a line
// restarts it; a tick with no line running gives no result. One request is
// taken per clock while the queue has room; a tick is queued, then popped
// by the back end, which registers its pixel. The line setup is combinational
// subtract and compare logic in the front end, each step is one decision add
// in the back end, and a command queue of two entries by default lies between.
// Depends on blp_pkg, blp_front, blp_queue and blp_back.
module bresenham_line_stepper import blp_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // x_start, y_start, x_end, y_end, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,
    // req_type
    input  logic                                  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // pixel_x, pixel_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     o_m_tdata,
    // last_pixel
    output logic                                  o_m_tlast
);

    localparam int N     = COORD_BITS;
    localparam int CMD_W = cmd_bits(COORD_BITS);
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

    logic             q_push;
    logic             q_ready;
    logic             q_valid;
    logic             q_pop;
    logic [CMD_W-1:0] q_wdata;
    logic [CMD_W-1:0] q_rdata;
    logic [N-1:0]     pix_x;
    logic [N-1:0]     pix_y;

    blp_front #(.N(N)) u_front (
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_req_type (i_s_tuser),
        .i_x_start  (i_s_tdata[N-1:0]),
        .i_y_start  (i_s_tdata[2*N-1:N]),
        .i_x_end    (i_s_tdata[3*N-1:2*N]),
        .i_y_end    (i_s_tdata[4*N-1:3*N]),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    blp_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (q_pop)
    );

    blp_back #(.N(N)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_pixel_x (pix_x),
        .o_pixel_y (pix_y),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = OUT_W'({pix_y, pix_x});

    // reset leaves no command queued and no pixel pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !q_valid)
        else $error("state not cleared by reset");

    // once the last pixel is taken with nothing queued, no pixel may follow
    a_no_extra_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast && i_m_tready && !q_valid |=> !o_m_tvalid)
        else $error("pixel emitted without a queued tick");

    // back pressure on the input only comes from a non-empty queue
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> q_valid)
        else $error("input stalled with empty queue");

endmodule
